[rtl/tksi_pkg.sv]
// ----------------------------------------------------------------------------
// tksi_pkg
// Shared types and constants of the top-k sorted insertion tables: the stored
// entry layout and the command and status groups between controller and
// datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tksi_pkg;

    // field widths
    localparam int SEL_W   = 2;
    localparam int TAG_W   = 8;
    localparam int SCORE_W = 16;
    localparam int COUNT_W = 8;
    localparam int RANK_W  = 4;

    // first table that breaks score ties on the secondary count
    localparam int COUNT_BASE = 2;

    // one stored table entry
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [COUNT_W-1:0] count;
        logic [TAG_W-1:0]   tag;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // controller to datapath
    typedef struct packed {
        logic load;      // capture the input transaction
        logic start_rd;  // read the last rank of the table
        logic scan;      // one compare and shift step
        logic finish;    // write rank 0 if beaten, load the result register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sel_ok;     // input table selector names an existing table
        logic last_step;  // scan is at rank 0
    } status_t;

endpackage

`default_nettype wire

[rtl/top_k_sorted_insert.sv]
// ----------------------------------------------------------------------------
// top_k_sorted_insert
// Keeps TABLE_COUNT descending top-k tables of TABLE_DEPTH entries and inserts
// one offered score per transaction, reporting whether and where it landed.
// ----------------------------------------------------------------------------
//
//   channel  handshake            payload
//   -------  -------------------  ------------------------------------------
//   in       in_valid / in_ready  table_sel, owner_tag, new_score, tie_count
//   out      out_valid/out_ready  placed, rank
//
// The result is registered after a read setup step, one RAM read and compare
// per rank from the last up, and the rank 0 write; an unknown table goes
// straight to the result. The next transaction is taken when the controller
// is back in idle, after the result of the last one has been registered.
// A finished result waits while the output register is full and stalls input.
// Reset clears per-entry valid bits, so all tables read as zero at once.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_sorted_insert #(
    parameter int TABLE_DEPTH = 10,
    parameter int TABLE_COUNT = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [tksi_pkg::SEL_W-1:0]    table_sel,
    input  wire logic [tksi_pkg::TAG_W-1:0]    owner_tag,
    input  wire logic [tksi_pkg::SCORE_W-1:0]  new_score,
    input  wire logic [tksi_pkg::COUNT_W-1:0]  tie_count,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               placed,
    output logic      [tksi_pkg::RANK_W-1:0]   rank
);

    tksi_pkg::cmd_t    cmd;
    tksi_pkg::status_t status;

    // controller
    tksi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath
    tksi_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TABLE_COUNT (TABLE_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .table_sel (table_sel),
        .owner_tag (owner_tag),
        .new_score (new_score),
        .tie_count (tie_count),
        .placed    (placed),
        .rank      (rank)
    );

endmodule

`default_nettype wire

[rtl/tksi_ram.sv]
// ----------------------------------------------------------------------------
// tksi_ram
// Generic simple dual-port RAM: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tksi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 40
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/tksi_ctrl.sv]
// ----------------------------------------------------------------------------
// tksi_ctrl
// Controller state machine: takes one transaction at a time, walks the scan
// from the last rank to rank 0 and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tksi_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire tksi_pkg::status_t status,
    output tksi_pkg::cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_FIRST  = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.sel_ok ? ST_FIRST : ST_FINISH;
                end
            end
            ST_FIRST:
            begin
                cmd.start_rd = 1'b1;
                state_next   = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.last_step)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // wait for a free output slot
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[rtl/tksi_dp.sv]
// ----------------------------------------------------------------------------
// tksi_dp
// Datapath: table RAM with per-entry valid bits, offer registers, the beat
// compare and the shift-down writes, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tksi_dp #(
    parameter int TABLE_DEPTH = 10,
    parameter int TABLE_COUNT = 4
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire tksi_pkg::cmd_t                 cmd,
    output tksi_pkg::status_t                   status,
    input  wire logic [tksi_pkg::SEL_W-1:0]     table_sel,
    input  wire logic [tksi_pkg::TAG_W-1:0]     owner_tag,
    input  wire logic [tksi_pkg::SCORE_W-1:0]   new_score,
    input  wire logic [tksi_pkg::COUNT_W-1:0]   tie_count,
    output logic                                placed,
    output logic      [tksi_pkg::RANK_W-1:0]    rank
);

    localparam int ENTRIES = TABLE_DEPTH * TABLE_COUNT;
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [ADDR_W-1:0] DEPTH_A  = ADDR_W'(TABLE_DEPTH);

    // offer and scan registers
    logic [tksi_pkg::SEL_W-1:0] sel_reg;
    tksi_pkg::entry_t           offer_reg;
    logic [ADDR_W-1:0]          base_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic                       beat_prev_reg;
    logic                       placed_reg;
    logic [IDX_W-1:0]           rank_idx_reg;
    logic [ENTRIES-1:0]         valid_reg;
    logic                       rd_valid_reg;
    logic                       out_placed_reg;
    logic [tksi_pkg::RANK_W-1:0] out_rank_reg;

    // RAM ports
    logic                         wr_en;
    logic [ADDR_W-1:0]            wr_addr;
    tksi_pkg::entry_t             wr_data;
    logic                         rd_en;
    logic [ADDR_W-1:0]            rd_addr;
    logic [IDX_W-1:0]             rd_idx;
    logic [tksi_pkg::ENTRY_W-1:0] rd_data;

    tksi_pkg::entry_t cur_entry;
    logic             counted;
    logic             beat;

    tksi_ram #(
        .WIDTH (tksi_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // status to the controller
    assign status.sel_ok    = (int'(table_sel) < TABLE_COUNT);
    assign status.last_step = (idx_reg == '0);

    // read address: last rank first, then one rank up per scan step
    always_comb
    begin
        rd_en  = cmd.start_rd || (cmd.scan && (idx_reg != '0));
        rd_idx = cmd.start_rd ? LAST_IDX : (idx_reg - 1'b1);
        if (!rd_en)
        begin
            rd_idx = '0;
        end
        rd_addr = base_reg + ADDR_W'(rd_idx);
    end

    // never written entries read as zero
    assign cur_entry = rd_valid_reg ? tksi_pkg::entry_t'(rd_data) : '0;

    // beat compare against the stored entry at the current rank
    assign counted = (int'(sel_reg) >= tksi_pkg::COUNT_BASE);
    always_comb
    begin
        if (offer_reg.score > cur_entry.score)
        begin
            beat = 1'b1;
        end
        else if (offer_reg.score == cur_entry.score)
        begin
            beat = counted ? (offer_reg.count >= cur_entry.count) : 1'b1;
        end
        else
        begin
            beat = 1'b0;
        end
    end

    // writes: rank below the current one during the scan, rank 0 at the end
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = base_reg;
        wr_data = offer_reg;
        if (cmd.scan)
        begin
            wr_en   = (idx_reg != LAST_IDX) && (beat || beat_prev_reg);
            wr_addr = base_reg + ADDR_W'(IDX_W'(idx_reg + 1'b1));
            wr_data = beat ? cur_entry : offer_reg;
        end
        else if (cmd.finish)
        begin
            wr_en = beat_prev_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sel_reg         <= table_sel;
            offer_reg.score <= new_score;
            offer_reg.count <= tie_count;
            offer_reg.tag   <= owner_tag;
            base_reg        <= ADDR_W'(ADDR_W'(table_sel) * DEPTH_A);
        end
        if (rd_en)
        begin
            rd_valid_reg <= valid_reg[rd_addr];
        end
        if (cmd.finish)
        begin
            out_placed_reg <= placed_reg;
            out_rank_reg   <= tksi_pkg::RANK_W'(rank_idx_reg);
        end
    end

    // scan control and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            beat_prev_reg <= 1'b0;
            placed_reg    <= 1'b0;
            rank_idx_reg  <= '0;
            valid_reg     <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg       <= LAST_IDX;
                beat_prev_reg <= 1'b0;
                placed_reg    <= 1'b0;
                rank_idx_reg  <= '0;
            end
            else if (cmd.scan)
            begin
                beat_prev_reg <= beat;
                if (idx_reg != '0)
                begin
                    idx_reg <= idx_reg - 1'b1;
                end
                if (beat)
                begin
                    placed_reg   <= 1'b1;
                    rank_idx_reg <= idx_reg;
                end
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign placed = out_placed_reg;
    assign rank   = out_rank_reg;

endmodule

`default_nettype wire

[tb/tb_top_k_sorted_insert.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top_k_sorted_insert
// Self-checking bench for the four top-ten score tables. A queue-fed driver
// offers scores, an in-bench table model predicts placement and rank per
// accepted transaction, and a monitor checks each result in order. Phases vary
// sender gaps and receiver stalls, with one long output hold-off.
// ----------------------------------------------------------------------------

module tb_top_k_sorted_insert;

    localparam int DEPTH           = 10;
    localparam int TABLES          = 4;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 40;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASE_ITEMS     = 150;

    // one offered score
    typedef struct packed {
        logic [tksi_pkg::SEL_W-1:0]   sel;
        logic [tksi_pkg::TAG_W-1:0]   tag;
        logic [tksi_pkg::SCORE_W-1:0] score;
        logic [tksi_pkg::COUNT_W-1:0] cnt;
    } offer_t;

    // placement outcome of one offer
    typedef struct packed {
        logic                        placed;
        logic [tksi_pkg::RANK_W-1:0] rank;
    } placement_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    logic [tksi_pkg::SEL_W-1:0]     table_sel = '0;
    logic [tksi_pkg::TAG_W-1:0]     owner_tag = '0;
    logic [tksi_pkg::SCORE_W-1:0]   new_score = '0;
    logic [tksi_pkg::COUNT_W-1:0]   tie_count = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic                           placed;
    logic [tksi_pkg::RANK_W-1:0]    rank;

    // model tables, best entry at index 0
    logic [tksi_pkg::SCORE_W-1:0]   score_tbl [TABLES][DEPTH] = '{default: '0};
    logic [tksi_pkg::COUNT_W-1:0]   count_tbl [TABLES][DEPTH] = '{default: '0};
    logic [tksi_pkg::TAG_W-1:0]     tag_tbl   [TABLES][DEPTH] = '{default: '0};

    offer_t                         pending_offers [$];
    placement_t                     expected_placements [$];
    logic [tksi_pkg::SCORE_W-1:0]   recent_score [TABLES] = '{default: '0};

    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    int                   stall_req      = 0;
    int                   stall_left     = 0;
    int                   cycle_count    = 0;
    int                   error_count    = 0;
    int                   offers_taken   = 0;
    int                   results_seen   = 0;
    int                   placed_seen    = 0;
    int                   top_rank_seen  = 0;
    int                   gen_count      = 0;

    top_k_sorted_insert #(
        .TABLE_DEPTH (DEPTH),
        .TABLE_COUNT (TABLES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .table_sel (table_sel),
        .owner_tag (owner_tag),
        .new_score (new_score),
        .tie_count (tie_count),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .placed    (placed),
        .rank      (rank)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // insert one offer into the model tables, scanning from the last rank up
    function automatic placement_t insert_score(offer_t o);
        placement_t res;
        bit         counted;
        bit         wins;
        int         t;
        res = '0;
        t   = int'(o.sel);
        if (t < TABLES)
        begin
            counted = (t >= tksi_pkg::COUNT_BASE);
            for (int n = DEPTH - 1; n >= 0; n--)
            begin
                if (o.score > score_tbl[t][n])
                    wins = 1'b1;
                else if (o.score == score_tbl[t][n])
                    wins = counted ? (o.cnt >= count_tbl[t][n]) : 1'b1;
                else
                    wins = 1'b0;
                if (wins)
                begin
                    // beaten entry moves down one rank
                    if (n < DEPTH - 1)
                    begin
                        score_tbl[t][n+1] = score_tbl[t][n];
                        tag_tbl[t][n+1]   = tag_tbl[t][n];
                        if (counted)
                            count_tbl[t][n+1] = count_tbl[t][n];
                    end
                    score_tbl[t][n] = o.score;
                    tag_tbl[t][n]   = o.tag;
                    if (counted)
                        count_tbl[t][n] = o.cnt;
                    res.placed = 1'b1;
                    res.rank   = tksi_pkg::RANK_W'(n);
                end
            end
        end
        return res;
    endfunction

    // input driver, fed from the pending offer queue
    always @(posedge clk or negedge rst_n)
    begin : driver
        offer_t nxt;
        offer_t taken;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            table_sel <= '0;
            owner_tag <= '0;
            new_score <= '0;
            tie_count <= '0;
        end
        else
        begin
            // predict on every accepted transaction
            if (in_valid && in_ready)
            begin
                taken.sel   = table_sel;
                taken.tag   = owner_tag;
                taken.score = new_score;
                taken.cnt   = tie_count;
                expected_placements.push_back(insert_score(taken));
                offers_taken++;
            end
            // load the next offer once the current one is gone
            if (!in_valid || in_ready)
            begin
                if (pending_offers.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt        = pending_offers.pop_front();
                    table_sel <= nxt.sel;
                    owner_tag <= nxt.tag;
                    new_score <= nxt.score;
                    tie_count <= nxt.cnt;
                    in_valid  <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long output hold-off counter
    always @(posedge clk)
    begin
        if (stall_req > 0)
        begin
            stall_left <= stall_req;
            stall_req  <= 0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
    end

    // result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin : monitor
        placement_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (placed)
                    placed_seen++;
                if (placed && rank == '0)
                    top_rank_seen++;
                if (expected_placements.size() == 0)
                begin
                    $error("unexpected result: placed=%0d rank=%0d", placed, rank);
                    error_count++;
                end
                else
                begin
                    want = expected_placements.pop_front();
                    if (placed !== want.placed)
                    begin
                        $error("placed mismatch: expected %0d, got %0d", want.placed, placed);
                        error_count++;
                    end
                    if (rank !== want.rank)
                    begin
                        $error("rank mismatch: expected %0d, got %0d", want.rank, rank);
                        error_count++;
                    end
                end
            end
            out_ready <= (stall_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_offer(input int sel, input int tag, input int score, input int cnt);
        offer_t o;
        o.sel   = tksi_pkg::SEL_W'(sel);
        o.tag   = tksi_pkg::TAG_W'(tag);
        o.score = tksi_pkg::SCORE_W'(score);
        o.cnt   = tksi_pkg::COUNT_W'(cnt);
        pending_offers.push_back(o);
    endtask

    // sender pauses here until every result is back
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_offers.size() != 0 || in_valid || expected_placements.size() != 0);
    endtask

    // random offers: mostly a rising score window and repeats for ties
    task automatic random_phase(input int n_items, input int send_pct, input int recv_pct);
        offer_t o;
        int     pick;
        int     base;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int k = 0; k < n_items; k++)
        begin
            o.sel = tksi_pkg::SEL_W'($urandom_range(0, TABLES - 1));
            o.tag = tksi_pkg::TAG_W'($urandom);
            base  = (gen_count * 109 > 63000) ? 63000 : gen_count * 109;
            pick  = $urandom_range(0, 99);
            if (pick < 50)
                o.score = tksi_pkg::SCORE_W'(base + $urandom_range(0, 2000));
            else if (pick < 75)
                o.score = recent_score[o.sel];
            else if (pick < 85)
                o.score = tksi_pkg::SCORE_W'($urandom_range(0, 3));
            else if (pick < 93)
                o.score = tksi_pkg::SCORE_W'($urandom);
            else
                o.score = $urandom_range(0, 1) ? '1 : '0;
            o.cnt = ($urandom_range(0, 99) < 70) ? tksi_pkg::COUNT_W'($urandom_range(0, 3))
                                                 : tksi_pkg::COUNT_W'($urandom);
            recent_score[o.sel] = o.score;
            gen_count++;
            pending_offers.push_back(o);
        end
        wait_drained();
    endtask

    // stimulus sequence
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed offers behind a long output hold-off, no idling
        stall_req <= HOLD_OFF_CYCLES;
        push_offer(0, 0, 0, 0);              // zero score on a fresh table
        push_offer(1, 255, 16'hFFFF, 255);   // top score
        push_offer(2, 1, 100, 10);
        push_offer(2, 2, 100, 10);           // equal count goes above
        push_offer(2, 3, 100, 9);            // lower count stays below
        push_offer(2, 4, 100, 11);
        push_offer(3, 5, 0, 255);
        push_offer(3, 6, 0, 0);              // zero ties lose to larger count
        push_offer(3, 7, 0, 254);
        for (int i = 0; i < 9; i++)
            push_offer(0, 16 + i, 16'hFFFF, i);  // plain ties fill table 0
        push_offer(0, 8, 1, 0);              // lands on the last rank
        push_offer(0, 9, 0, 0);              // table full, not placed
        push_offer(1, 10, 16'hFFFE, 0);
        push_offer(3, 11, 16'hFFFF, 0);
        push_offer(3, 12, 16'hFFFF, 0);
        push_offer(2, 8'hAA, 16'hAAAA, 8'h55);
        push_offer(2, 8'h55, 16'h5555, 8'hAA);
        wait_drained();

        random_phase(PHASE_ITEMS, 0, 0);
        random_phase(PHASE_ITEMS, 63, 0);
        random_phase(PHASE_ITEMS, 0, 63);
        random_phase(PHASE_ITEMS, 27, 27);

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("offered %0d scores to %0d tables, %0d results checked", offers_taken,
                 TABLES, results_seen);
        $display("%0d placed (%0d at the top rank), %0d rejected by a full table",
                 placed_seen, top_rank_seen, results_seen - placed_seen);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[top_k_sorted_insert.f]
rtl/tksi_pkg.sv
rtl/tksi_ram.sv
rtl/tksi_ctrl.sv
rtl/tksi_dp.sv
rtl/top_k_sorted_insert.sv
tb/tb_top_k_sorted_insert.sv
